>>> rtl/wmca_pkg.sv
package wmca_pkg;

  localparam int CoordW   = 24;
  localparam int WeightW  = 16;
  localparam int SumW     = 32;
  localparam int TotalW   = SumW + 1;
  localparam int CovW     = 48;
  localparam int NumCov   = 6;
  localparam int NumAxes  = 3;

  // shared shift-add multiplier: a is up to 48 bits, b up to 32 bits
  localparam int MulAW    = 48;
  localparam int MulBW    = 32;
  localparam int MulPW    = MulAW + MulBW;
  localparam int MulCntW  = $clog2(MulBW);

  // shared restoring divider: one quotient bit per cycle
  localparam int DivNW    = 80;
  localparam int DivDW    = TotalW;
  localparam int DivCntW  = $clog2(DivNW);

  localparam int InDataW  = 3 * CoordW + WeightW;
  localparam int OutDataW = 3 * CoordW + SumW + NumCov * CovW;

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MA   = 10'b0000000010,
    S_MB   = 10'b0000000100,
    S_DM   = 10'b0000001000,
    S_MC   = 10'b0000010000,
    S_DC1  = 10'b0000100000,
    S_MD   = 10'b0001000000,
    S_ME   = 10'b0010000000,
    S_DC2  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_e;

  // covariance entry order xx yy zz xy yz zx
  function automatic logic [1:0] pair_a(input logic [2:0] e);
    logic [1:0] r;
    unique case (e)
      3'd0, 3'd3: r = 2'd0;
      3'd1, 3'd4: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] e);
    logic [1:0] r;
    unique case (e)
      3'd0, 3'd5: r = 2'd0;
      3'd1, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/wmca_serial_mul.sv
module wmca_serial_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wmca_pkg::MulAW-1:0] a_i,
  input  logic [wmca_pkg::MulBW-1:0] b_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [wmca_pkg::MulPW-1:0] product_o
);
  import wmca_pkg::*;

  logic               busy_q, busy_d, done_q, done_d;
  logic [MulCntW-1:0] cnt_q, cnt_d;
  logic [MulAW-1:0]   a_q, a_d, hi_q, hi_d;
  logic [MulBW-1:0]   lo_q, lo_d;
  logic [MulAW:0]     sum;

  // one multiplier bit per cycle, partial product shifts right
  assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : {(MulAW+1){1'b0}});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      hi_d   = '0;
      lo_d   = b_i;
    end else if (busy_q) begin
      hi_d  = sum[MulAW:1];
      lo_d  = {sum[0], lo_q[MulBW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MulCntW'(MulBW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign busy_o    = busy_q;
  assign done_o    = done_q;
  assign product_o = {hi_q, lo_q};

endmodule

>>> rtl/wmca_serial_div.sv
module wmca_serial_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wmca_pkg::DivNW-1:0] dividend_i,
  input  logic [wmca_pkg::DivDW-1:0] divisor_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [wmca_pkg::DivNW-1:0] quotient_o
);
  import wmca_pkg::*;

  logic               busy_q, busy_d, done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivNW-1:0]   dq_q, dq_d;
  logic [DivDW-1:0]   rem_q, rem_d, dvs_q, dvs_d;
  logic [DivDW:0]     r2, dvs_x;
  logic               ge;

  // dividend shifts out the top while quotient bits shift in below
  assign r2    = {rem_q, dq_q[DivNW-1]};
  assign dvs_x = {1'b0, dvs_q};
  assign ge    = (r2 >= dvs_x);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? DivDW'(r2 - dvs_x) : r2[DivDW-1:0];
      dq_d  = {dq_q[DivNW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivNW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

>>> rtl/weighted_mean_covariance_accumulator_core.sv
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata: x y z weight, tuser: op
// m_axis    out  m_axis_tvalid/tready       tdata: mean xyz, weight_total, 6 cov
//
// a clear goes straight to the done state; a point takes per used
// axis one 32-step multiply pair and one 80-step divide, per covariance entry
// three 32-step multiplies and two 80-step divides, all on one shared
// bit-serial multiplier and one shared restoring divider
// reset zeroes mean, weight and covariance and empties the output register
// s_axis_tready is high whenever the sequencer is idle, even while a result
// waits in the output register; the sequencer stalls only on delivery
module weighted_mean_covariance_accumulator_core #(
  parameter int DIMENSIONS = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // point_x, point_y, point_z, point_weight
  input  logic [wmca_pkg::InDataW-1:0]  s_axis_tdata,
  // op
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // mean_x, mean_y, mean_z, weight_total, cov_xx, cov_yy, cov_zz,
  // cov_xy, cov_yz, cov_zx
  output logic [wmca_pkg::OutDataW-1:0] m_axis_tdata
);
  import wmca_pkg::*;

  localparam logic [CovW-1:0] CovMax = {1'b0, {(CovW-1){1'b1}}};
  localparam logic [CovW-1:0] CovMin = {1'b1, {(CovW-1){1'b0}}};

  state_e state_q, state_d;

  // cluster state
  logic [CoordW-1:0]  mean_q [NumAxes];
  logic [CoordW-1:0]  mean_d [NumAxes];
  logic [CovW-1:0]    cov_q  [NumCov];
  logic [CovW-1:0]    cov_d  [NumCov];
  logic [SumW-1:0]    wsum_q, wsum_d;

  // per-transaction working registers
  logic [CoordW-1:0]  px_q [NumAxes];
  logic [CoordW-1:0]  px_d [NumAxes];
  logic [WeightW-1:0] pw_q, pw_d;
  logic [TotalW-1:0]  total_q, total_d;
  logic [2:0]         idx_q, idx_d;
  logic [DivNW-1:0]   t_q, t_d;
  logic [CovW-1:0]    q1_q, q1_d;
  logic               sgn_q, sgn_d;
  logic               run_q, run_d;
  logic               mvalid_q, mvalid_d;
  logic               load_out;
  logic [OutDataW-1:0] out_q;

  logic               s_fire;
  logic [TotalW-1:0]  tot_in;
  logic [1:0]         ax, pa, pb;
  logic [CoordW-1:0]  mean_mag, p_mag, q24;
  logic [CovW-1:0]    cov_mag;
  logic [CoordW:0]    da, db, da_neg, db_neg;
  logic [CoordW-1:0]  da_mag, db_mag;
  logic               neg2, cov_skip, mean_skip;
  logic [57:0]        n1, n2, num, num_mag;
  logic [48:0]        q2;
  logic [50:0]        s1, s2, ssum;

  logic               mul_start, mul_busy, mul_done;
  logic [MulAW-1:0]   mul_a;
  logic [MulBW-1:0]   mul_b;
  logic [MulPW-1:0]   mul_p;
  logic               div_start, div_busy, div_done;
  logic [DivNW-1:0]   div_n;
  logic [DivDW-1:0]   div_dv;
  logic [DivNW-1:0]   div_q;

  wmca_serial_mul u_mul (
    .clk_i, .rst_ni,
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .busy_o    (mul_busy),
    .done_o    (mul_done),
    .product_o (mul_p)
  );

  wmca_serial_div u_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_dv),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign tot_in        = {1'b0, wsum_q} + TotalW'(s_axis_tdata[3*CoordW +: WeightW]);

  // operand magnitudes for the current axis or covariance entry
  assign ax       = idx_q[1:0];
  assign pa       = pair_a(idx_q);
  assign pb       = pair_b(idx_q);
  assign mean_mag = mean_q[ax][CoordW-1] ? CoordW'(~mean_q[ax] + 1'b1) : mean_q[ax];
  assign p_mag    = px_q[ax][CoordW-1] ? CoordW'(~px_q[ax] + 1'b1) : px_q[ax];
  assign cov_mag  = cov_q[idx_q][CovW-1] ? CovW'(~cov_q[idx_q] + 1'b1) : cov_q[idx_q];
  assign da       = {mean_q[pa][CoordW-1], mean_q[pa]} - {px_q[pa][CoordW-1], px_q[pa]};
  assign db       = {mean_q[pb][CoordW-1], mean_q[pb]} - {px_q[pb][CoordW-1], px_q[pb]};
  assign da_neg   = ~da + 1'b1;
  assign db_neg   = ~db + 1'b1;
  assign da_mag   = da[CoordW] ? da_neg[CoordW-1:0] : da[CoordW-1:0];
  assign db_mag   = db[CoordW] ? db_neg[CoordW-1:0] : db[CoordW-1:0];
  assign neg2     = da[CoordW] ^ db[CoordW];

  assign mean_skip = (int'(ax) >= DIMENSIONS);
  assign cov_skip  = (int'(pa) >= DIMENSIONS) || (int'(pb) >= DIMENSIONS) || (wsum_q == '0);

  // signed numerator of the mean: W*mean + w*p
  assign n1      = {2'b00, t_q[55:0]};
  assign n2      = {18'b0, mul_p[39:0]};
  assign num     = (mean_q[ax][CoordW-1] ? (~n1 + 1'b1) : n1)
                 + (px_q[ax][CoordW-1] ? (~n2 + 1'b1) : n2);
  assign num_mag = num[57] ? (~num + 1'b1) : num;
  assign q24     = div_q[CoordW-1:0];

  // covariance combine with clamp of the second term at 2^48
  assign q2   = ((|div_q[DivNW-1:49]) || (div_q[48] && (|div_q[47:0])))
              ? {1'b1, 48'b0} : div_q[48:0];
  assign s1   = cov_q[idx_q][CovW-1] ? (~{3'b0, q1_q} + 1'b1) : {3'b0, q1_q};
  assign s2   = {2'b0, q2};
  assign ssum = neg2 ? (s1 - s2) : (s1 + s2);

  always_comb begin
    state_d  = state_q;
    mean_d   = mean_q;
    cov_d    = cov_q;
    wsum_d   = wsum_q;
    px_d     = px_q;
    pw_d     = pw_q;
    total_d  = total_q;
    idx_d    = idx_q;
    t_d      = t_q;
    q1_d     = q1_q;
    sgn_d    = sgn_q;
    run_d    = run_q;
    load_out = 1'b0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = t_q;
    div_dv    = total_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if (op_e'(s_axis_tuser) == OP_CLEAR) begin
            for (int i = 0; i < NumAxes; i++) mean_d[i] = '0;
            for (int i = 0; i < NumCov; i++) cov_d[i] = '0;
            wsum_d  = '0;
            state_d = S_DONE;
          end else begin
            for (int i = 0; i < NumAxes; i++) px_d[i] = s_axis_tdata[i*CoordW +: CoordW];
            pw_d    = s_axis_tdata[3*CoordW +: WeightW];
            total_d = tot_in;
            idx_d   = '0;
            state_d = (tot_in == '0) ? S_DONE : S_MA;
          end
        end
      end
      S_MA: begin
        if (mean_skip) begin
          mean_d[ax] = '0;
          if (ax == 2'd2) begin
            idx_d   = '0;
            state_d = S_MC;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else if (!run_q) begin
          mul_start = 1'b1;
          mul_a     = MulAW'(mean_mag);
          mul_b     = wsum_q;
          run_d     = 1'b1;
        end else if (mul_done) begin
          run_d   = 1'b0;
          t_d     = DivNW'(mul_p);
          state_d = S_MB;
        end
      end
      S_MB: begin
        if (!run_q) begin
          mul_start = 1'b1;
          mul_a     = MulAW'(p_mag);
          mul_b     = MulBW'(pw_q);
          run_d     = 1'b1;
        end else if (mul_done) begin
          run_d   = 1'b0;
          sgn_d   = num[57];
          t_d     = DivNW'(num_mag);
          state_d = S_DM;
        end
      end
      S_DM: begin
        if (!run_q) begin
          div_start = 1'b1;
          run_d     = 1'b1;
        end else if (div_done) begin
          run_d      = 1'b0;
          mean_d[ax] = sgn_q ? CoordW'(~q24 + 1'b1) : q24;
          if (ax == 2'd2) begin
            idx_d   = '0;
            state_d = S_MC;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_MA;
          end
        end
      end
      S_MC: begin
        if (cov_skip) begin
          cov_d[idx_q] = '0;
          if (idx_q == 3'(NumCov - 1)) begin
            wsum_d  = total_q[SumW] ? {SumW{1'b1}} : total_q[SumW-1:0];
            state_d = S_DONE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else if (!run_q) begin
          mul_start = 1'b1;
          mul_a     = cov_mag;
          mul_b     = wsum_q;
          run_d     = 1'b1;
        end else if (mul_done) begin
          run_d   = 1'b0;
          t_d     = mul_p;
          state_d = S_DC1;
        end
      end
      S_DC1: begin
        if (!run_q) begin
          div_start = 1'b1;
          run_d     = 1'b1;
        end else if (div_done) begin
          run_d   = 1'b0;
          q1_d    = div_q[CovW-1:0];
          state_d = S_MD;
        end
      end
      S_MD: begin
        if (!run_q) begin
          mul_start = 1'b1;
          mul_a     = MulAW'(da_mag);
          mul_b     = MulBW'(db_mag);
          run_d     = 1'b1;
        end else if (mul_done) begin
          run_d   = 1'b0;
          t_d     = mul_p;
          state_d = S_ME;
        end
      end
      S_ME: begin
        if (!run_q) begin
          mul_start = 1'b1;
          mul_a     = t_q[MulAW-1:0];
          mul_b     = MulBW'(pw_q);
          run_d     = 1'b1;
        end else if (mul_done) begin
          run_d   = 1'b0;
          t_d     = mul_p;
          state_d = S_DC2;
        end
      end
      S_DC2: begin
        div_dv = {1'b0, wsum_q};
        if (!run_q) begin
          div_start = 1'b1;
          run_d     = 1'b1;
        end else if (div_done) begin
          run_d = 1'b0;
          if (!ssum[50] && (ssum > {3'b0, CovMax})) begin
            cov_d[idx_q] = CovMax;
          end else if (ssum[50] && (ssum < {3'b111, CovMin})) begin
            cov_d[idx_q] = CovMin;
          end else begin
            cov_d[idx_q] = ssum[CovW-1:0];
          end
          if (idx_q == 3'(NumCov - 1)) begin
            wsum_d  = total_q[SumW] ? {SumW{1'b1}} : total_q[SumW-1:0];
            state_d = S_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_MC;
          end
        end
      end
      S_DONE: begin
        // wait only if the previous result is still parked
        if (!mvalid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign mvalid_d = load_out ? 1'b1 : (m_axis_tready ? 1'b0 : mvalid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      for (int i = 0; i < NumAxes; i++) mean_q[i] <= '0;
      for (int i = 0; i < NumCov; i++) cov_q[i] <= '0;
      wsum_q   <= '0;
      idx_q    <= '0;
      run_q    <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mean_q   <= mean_d;
      cov_q    <= cov_d;
      wsum_q   <= wsum_d;
      idx_q    <= idx_d;
      run_q    <= run_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    pw_q    <= pw_d;
    total_q <= total_d;
    t_q     <= t_d;
    q1_q    <= q1_d;
    sgn_q   <= sgn_d;
    if (load_out) begin
      out_q <= {cov_q[5], cov_q[4], cov_q[3], cov_q[2], cov_q[1], cov_q[0],
                wsum_q, mean_q[2], mean_q[1], mean_q[0]};
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = out_q;

  // the two arithmetic units never overlap
  a_units_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_busy && div_busy))
    else $error("multiplier and divider busy together");

  a_mul_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy)
    else $error("multiplier restarted while busy");

  a_div_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // weight only grows unless a clear came in
  a_weight_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_fire && s_axis_tuser) |=> (wsum_q >= $past(wsum_q)))
    else $error("total weight decreased without a clear");

  a_result_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(mvalid_q) |-> $past(state_q == S_DONE))
    else $error("result shown outside the done state");

endmodule
